// ===== hdl/circular_queue_with_replace_core_assert.svh =====
`ifndef CIRCULAR_QUEUE_WITH_REPLACE_CORE_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_REPLACE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CQR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CQR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cqr_pkg.sv =====
package cqr_pkg;

    localparam int DEPTH = 8;
    localparam int DW    = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;
    typedef logic [CW:0]   t_sum;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DELETE  = 2'd1,
        ACT_DISPLAY = 2'd2,
        ACT_MODIFY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_WALK
    } t_state;

    typedef struct packed {
        logic          we;
        t_addr         waddr;
        logic [DW-1:0] wdata;
        t_addr         raddr;
    } t_mem_req;

    typedef struct packed {
        logic    strobe;
        t_status status;
        logic    last;
        logic    use_rd;
    } t_res_ctl;

    function automatic t_addr wrap_inc(input t_addr p);
        return (p == t_addr'(DEPTH - 1)) ? '0 : t_addr'(p + 1'b1);
    endfunction

    function automatic t_addr wrap_add(input t_addr base, input t_count off);
        t_sum s;
        s = t_sum'(base) + t_sum'(off);
        if (s >= t_sum'(DEPTH)) begin
            s = s - t_sum'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

// ===== hdl/cqr_ram.sv =====
module cqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cqr_ctrl.sv =====
module cqr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  cqr_pkg::t_action      i_action,
    input  logic signed [31:0]    i_value,
    input  logic signed [31:0]    i_match_value,
    input  logic [31:0]           i_rd_data,
    output cqr_pkg::t_mem_req     o_mem,
    output cqr_pkg::t_res_ctl     o_res
);

    import cqr_pkg::*;

    t_state        r_state, n_state;
    t_addr         r_head, n_head;
    t_count        r_count, n_count;
    t_addr         r_idx, n_idx;
    t_addr         r_ptr, n_ptr;
    logic          r_found, n_found;
    t_action       r_act, n_act;
    logic [DW-1:0] r_value, n_value;
    logic [DW-1:0] r_match, n_match;

    logic w_accept;
    logic w_empty;
    logic w_full;
    logic w_hit;
    logic w_last_elem;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == t_count'(DEPTH));
    assign w_hit       = (i_rd_data == r_match);
    assign w_last_elem = ((t_count'(r_idx) + t_count'(1)) == r_count);
    assign o_busy      = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !w_empty) begin
                    if (i_action == ACT_DELETE) begin
                        n_state = S_DEL;
                    end else if (i_action inside {ACT_DISPLAY, ACT_MODIFY}) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_DEL: begin
                n_state = S_IDLE;
            end
            S_WALK: begin
                if (w_last_elem) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory requests and result control
    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_ptr;
        o_mem.wdata = r_value;
        o_mem.raddr = r_head;
        o_res.strobe = 1'b0;
        o_res.status = ST_OK;
        o_res.last   = 1'b0;
        o_res.use_rd = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_INSERT) begin
                        o_res.strobe = 1'b1;
                        o_res.last   = 1'b1;
                        if (w_full) begin
                            o_res.status = ST_OVERFLOW;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = wrap_add(r_head, r_count);
                            o_mem.wdata = i_value;
                        end
                    end else if (w_empty) begin
                        o_res.strobe = 1'b1;
                        o_res.status = ST_EMPTY;
                        o_res.last   = 1'b1;
                    end
                end
            end
            S_DEL: begin
                o_res.strobe = 1'b1;
                o_res.last   = 1'b1;
                o_res.use_rd = 1'b1;
            end
            S_WALK: begin
                o_mem.raddr = wrap_inc(r_ptr);
                if (r_act == ACT_MODIFY) begin
                    o_mem.we = w_hit;
                    if (w_last_elem) begin
                        o_res.strobe = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = (r_found || w_hit) ? ST_OK : ST_NOT_FOUND;
                    end
                end else begin
                    o_res.strobe = 1'b1;
                    o_res.last   = w_last_elem;
                    o_res.use_rd = 1'b1;
                end
            end
            default: begin
                o_res.strobe = 1'b0;
            end
        endcase
    end

    // queue pointers and walk state
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_idx   = r_idx;
        n_ptr   = r_ptr;
        n_found = r_found;
        n_act   = r_act;
        n_value = r_value;
        n_match = r_match;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_act   = i_action;
                    n_value = i_value;
                    n_match = i_match_value;
                    n_idx   = '0;
                    n_ptr   = r_head;
                    n_found = 1'b0;
                    if (i_action == ACT_INSERT) begin
                        if (!w_full) begin
                            n_count = r_count + t_count'(1);
                        end
                    end else if (i_action == ACT_DELETE && !w_empty) begin
                        n_count = r_count - t_count'(1);
                        n_head  = (r_count == t_count'(1)) ? '0 : wrap_inc(r_head);
                    end
                end
            end
            S_WALK: begin
                n_idx   = t_addr'(r_idx + 1'b1);
                n_ptr   = wrap_inc(r_ptr);
                n_found = r_found || w_hit;
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_ptr   <= n_ptr;
        r_found <= n_found;
        r_act   <= n_act;
        r_value <= n_value;
        r_match <= n_match;
    end

`include "circular_queue_with_replace_core_assert.svh"

    `CQR_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= t_count'(DEPTH), "count above depth")
    `CQR_ASSERT_NOW(a_empty_head, i_clk, i_rst_n, r_count == '0, r_head == '0, "empty queue with head off zero")
    `CQR_ASSERT_NOW(a_no_write_del, i_clk, i_rst_n, r_state == S_DEL, !o_mem.we, "write during delete read")
    `CQR_ASSERT_NEXT(a_del_seq, i_clk, i_rst_n, w_accept && i_action == ACT_DELETE && !w_empty, r_state == S_DEL && o_res.strobe, "delete transfer not followed by result")
    `CQR_ASSERT_NOW(a_walk_bound, i_clk, i_rst_n, r_state == S_WALK, t_count'(r_idx) < r_count, "walk past held entries")

endmodule

// ===== hdl/circular_queue_with_replace_core.sv =====
// insert, overflow and empty results appear in the cycle after the transfer
// delete: result passes the S_DEL state, then the result register; display: n
// results, one per S_WALK entry; modify: one result at the end of the walk;
// n = words held; insert takes a new request every cycle; delete, display and
// modify hold busy, the single read port walking the memory one entry a cycle
// reset clears head, count and control; the word memory is not cleared
module circular_queue_with_replace_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_match_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic               o_last
);

    import cqr_pkg::*;

    t_mem_req      w_mem;
    t_res_ctl      w_res;
    logic [DW-1:0] w_rd_data;

    logic          r_valid;
    t_status       r_status;
    logic [DW-1:0] r_data;
    logic          r_last;

    cqr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_action      (t_action'(i_action)),
        .i_value       (i_value),
        .i_match_value (i_match_value),
        .i_rd_data     (w_rd_data),
        .o_mem         (w_mem),
        .o_res         (w_res)
    );

    cqr_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_res.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= w_res.status;
        r_last   <= w_res.last;
        r_data   <= w_res.use_rd ? w_rd_data : '0;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

endmodule
